// File: rtl/mf5_pkg.sv
// Package for the streaming 5x5 median filter: shared constants, register
// codes and the result tag type. No dependencies.
package mf5_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int WINDOW_RADIUS_DEF = 2;
   localparam int MAX_CHANNELS_DEF  = 3;

   // Fixed field widths
   localparam int PIX_W      = 8;
   localparam int NUM_FIELDS = 3;
   localparam int WORD_W     = PIX_W * NUM_FIELDS;
   localparam int ROW_W      = 12;
   localparam int COL_OUT_W  = 10;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int CHAN_W     = 2;
   localparam int ROW_LIMIT  = 4096;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_CHANNELS = 2'd2;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET    = 11'd640;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET   = 13'd480;
   localparam logic [CHAN_W-1:0]  CHANNELS_RESET = 2'd3;

   // Tag that travels with each result
   typedef struct packed {
      logic                 last;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
   } meta_type;

endpackage

// File: rtl/median_filter_5x5_stream_unit.sv
// Top level of the streaming median filter: register port, window, lanes
// and the result register. Depends on mf5_pkg, mf5_window and mf5_lane.
//
// Usage: pixels arrive in raster order on the req_ stream, one transfer
// per pixel, start_of_frame in req_tuser restarting the position. Each
// pixel whose window is complete (row and column both at least twice the
// radius) yields one transfer on the rsp_ stream carrying the per-channel
// medians and the centre row and column; rsp_tlast marks the last result
// of the frame. Border pixels yield nothing.
// Pipeline: a result passes the line store read, window load, compare
// matrix and rank select registers, then the result register.
// Throughput: one pixel per cycle unless stalled (below); the line store
// reads and writes one column word per pixel on separate ports.
// Stall: the whole pipeline holds while a result waits on rsp_tready;
// req_tready is low only then.
// Reset: position, window and pipeline clear, registers return to
// 640 x 480 with three channels; the line store is not cleared.
// Registers (csr_): 0x0 image_width, 0x4 image_height, 0x8 channel_count;
// write them only while the block is idle.
module median_filter_5x5_stream_unit
   import mf5_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF,
   parameter int MAX_CHANNELS  = MAX_CHANNELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // chan0 [7:0], chan1 [15:8], chan2 [23:16]
   input  logic [WORD_W-1:0]     req_tdata,
   // start_of_frame [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // median0 [7:0], median1 [15:8], median2 [23:16], center_row [35:24],
   // center_col [45:36], zero [47:46]
   output logic [47:0]           rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int WIN_SIDE  = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_AREA  = WIN_SIDE * WIN_SIDE;
   localparam int NUM_LANES = (MAX_CHANNELS < NUM_FIELDS) ? MAX_CHANNELS : NUM_FIELDS;
   localparam int EC_W      = $clog2(MAX_CHANNELS + 1) + 1;

   logic [IMG_W_W-1:0] width_ff;
   logic [IMG_H_W-1:0] height_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [EC_W-1:0]    ec;

   logic               enable;
   logic               win_valid;
   meta_type           win_meta;
   logic [WIN_AREA-1:0][WORD_W-1:0] win_data;
   meta_type           meta_a_ff, meta_b_ff;
   logic [NUM_LANES-1:0]            lane_valid;
   logic [NUM_LANES-1:0][PIX_W-1:0] lane_med;
   logic [NUM_FIELDS-1:0][PIX_W-1:0] med_in;

   logic                 out_valid_ff;
   meta_type             out_meta_ff;
   logic [NUM_FIELDS-1:0][PIX_W-1:0] out_med_ff;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         chan_ff   <= CHANNELS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:    width_ff  <= csr_pwdata[IMG_W_W-1:0];
            REG_HEIGHT:   height_ff <= csr_pwdata[IMG_H_W-1:0];
            REG_CHANNELS: chan_ff   <= csr_pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WIDTH:    csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:   csr_prdata = CSR_DATA_W'(height_ff);
         REG_CHANNELS: csr_prdata = CSR_DATA_W'(chan_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Channels in use: zero counts as one, clamped to the lanes built
   always_comb begin
      if (chan_ff == '0) begin
         ec = EC_W'(1);
      end else if (EC_W'(chan_ff) > EC_W'(MAX_CHANNELS)) begin
         ec = EC_W'(MAX_CHANNELS);
      end else begin
         ec = EC_W'(chan_ff);
      end
   end

   // Advance the whole pipeline unless a result waits
   assign enable     = !out_valid_ff || rsp_tready;
   assign req_tready = enable;

   mf5_window #(
      .MAX_WIDTH     (MAX_WIDTH),
      .WINDOW_RADIUS (WINDOW_RADIUS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (req_tvalid),
      .in_sof       (req_tuser),
      .in_pixel     (req_tdata),
      .image_width  (width_ff),
      .image_height (height_ff),
      .out_valid    (win_valid),
      .out_meta     (win_meta),
      .out_window   (win_data)
   );

   // One median lane per channel
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [WIN_AREA-1:0][PIX_W-1:0] vals;
      always_comb begin
         for (int n = 0; n < WIN_AREA; n++) begin
            vals[n] = win_data[n][l*PIX_W +: PIX_W];
         end
      end
      mf5_lane #(
         .WIN_AREA (WIN_AREA)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .in_valid   (win_valid),
         .in_vals    (vals),
         .out_valid  (lane_valid[l]),
         .out_median (lane_med[l])
      );
   end

   // Carry the tag alongside the lanes
   always_ff @(posedge clock) begin
      if (enable) begin
         meta_a_ff <= win_meta;
         meta_b_ff <= meta_a_ff;
      end
   end

   // Merge lanes, zero the unused channels
   always_comb begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
         med_in[k] = '0;
      end
      for (int k = 0; k < NUM_LANES; k++) begin
         if (EC_W'(k) < ec) begin
            med_in[k] = lane_med[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= lane_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_meta_ff <= meta_b_ff;
         out_med_ff  <= med_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_meta_ff.last;
   assign rsp_tdata  = {2'b00, out_meta_ff.col, out_meta_ff.row,
                        out_med_ff[2], out_med_ff[1], out_med_ff[0]};

`ifndef SYNTHESIS
   // Input is refused only while a result waits
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input refused with no result pending");
   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");
`endif

endmodule

// File: rtl/mf5_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mf5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mf5_window.sv
// Raster position counters, line store and square pixel window.
// Depends on mf5_pkg and mf5_ram.
module mf5_window
   import mf5_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF,
   localparam int WIN_SIDE     = 2 * WINDOW_RADIUS + 1,
   localparam int WIN_AREA     = WIN_SIDE * WIN_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic                             in_sof,
   input  logic [WORD_W-1:0]                in_pixel,
   input  logic [IMG_W_W-1:0]               image_width,
   input  logic [IMG_H_W-1:0]               image_height,
   output logic                             out_valid,
   output meta_type                         out_meta,
   output logic [WIN_AREA-1:0][WORD_W-1:0]  out_window
);

   localparam int LINES = 2 * WINDOW_RADIUS;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int WC_W  = (EW_W > IMG_W_W) ? EW_W : IMG_W_W;
   localparam int LS_W  = LINES * WORD_W;

   logic                accept;
   logic [WC_W-1:0]     width_x;
   logic [WC_W-1:0]     ew;
   logic [IMG_H_W-1:0]  eh;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    c0;
   logic [ROW_W-1:0]    r0;
   logic [WC_W-1:0]     c0_x;
   logic [WC_W-1:0]     col_ctr_x;
   meta_type            meta0;
   logic                produce0;

   logic                s1_valid_ff;
   logic [WORD_W-1:0]   s1_pixel_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_produce_ff;
   meta_type            s1_meta_ff;
   logic                s1_fwd_ff;
   logic [LS_W-1:0]     fwd_data_ff;

   logic [LS_W-1:0]     rd_data;
   logic [LS_W-1:0]     old_col;
   logic [LS_W-1:0]     wr_data;
   logic [WORD_W-1:0]   colv [WIN_SIDE];

   logic [WORD_W-1:0]   win_ff [WIN_SIDE][WIN_SIDE];
   logic                out_valid_ff;
   meta_type            out_meta_ff;

   assign accept = enable && in_valid;

   // Clamp the geometry to the supported range
   assign width_x = WC_W'(image_width);
   always_comb begin
      if (width_x < WC_W'(WIN_SIDE)) begin
         ew = WC_W'(WIN_SIDE);
      end else if (width_x > WC_W'(MAX_WIDTH)) begin
         ew = WC_W'(MAX_WIDTH);
      end else begin
         ew = width_x;
      end
      if (image_height < IMG_H_W'(WIN_SIDE)) begin
         eh = IMG_H_W'(WIN_SIDE);
      end else if (image_height > IMG_H_W'(ROW_LIMIT)) begin
         eh = IMG_H_W'(ROW_LIMIT);
      end else begin
         eh = image_height;
      end
   end

   // Position of the arriving pixel and the next position
   assign c0        = in_sof ? '0 : col_ff;
   assign r0        = in_sof ? '0 : row_ff;
   assign c0_x      = WC_W'(c0);
   assign col_ctr_x = c0_x - WC_W'(WINDOW_RADIUS);

   always_comb begin
      if (c0_x + WC_W'(1) >= ew) begin
         col_in = '0;
         if ({1'b0, r0} + IMG_H_W'(1) >= eh) begin
            row_in = '0;
         end else begin
            row_in = r0 + ROW_W'(1);
         end
      end else begin
         col_in = c0 + COL_W'(1);
         row_in = r0;
      end
   end

   assign produce0   = (r0 >= ROW_W'(LINES)) && (c0 >= COL_W'(LINES));
   assign meta0.last = ({1'b0, r0} == eh - IMG_H_W'(1)) && (c0_x == ew - WC_W'(1));
   assign meta0.row  = r0 - ROW_W'(WINDOW_RADIUS);
   assign meta0.col  = col_ctr_x[COL_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store, one word of all buffered lines per column
   mf5_ram #(
      .WIDTH (LS_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (enable && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (rd_data)
   );

   // Column entering the window; bypass a write to the same column
   assign old_col = s1_fwd_ff ? fwd_data_ff : rd_data;
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         colv[k] = old_col[k*WORD_W +: WORD_W];
      end
      colv[LINES] = s1_pixel_ff;
      for (int k = 0; k < LINES; k++) begin
         wr_data[k*WORD_W +: WORD_W] = colv[k+1];
      end
   end

   // Stage one: hold the transfer while the line store is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= accept;
         s1_fwd_ff   <= accept && s1_valid_ff && (s1_col_ff == c0);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fwd_data_ff <= wr_data;
         if (accept) begin
            s1_pixel_ff   <= in_pixel;
            s1_col_ff     <= c0;
            s1_produce_ff <= produce0;
            s1_meta_ff    <= meta0;
         end
      end
   end

   // Shift the window one column left and load the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_SIDE; i++) begin
            for (int j = 0; j < WIN_SIDE; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (enable && s1_valid_ff) begin
         for (int i = 0; i < WIN_SIDE; i++) begin
            for (int j = 0; j < WIN_SIDE - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][WIN_SIDE-1] <= colv[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= s1_valid_ff && s1_produce_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_meta_ff <= s1_meta_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_SIDE; i++) begin
         for (int j = 0; j < WIN_SIDE; j++) begin
            out_window[i*WIN_SIDE + j] = win_ff[i][j];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_meta  = out_meta_ff;

`ifndef SYNTHESIS
   // A bypass only stands for a write that is in stage one
   a_fwd_needs_writer: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> s1_valid_ff)
      else $error("line store bypass without a pending write");
   // A result never leaves stage one unless it was produced there
   a_out_from_stage1: assert property (@(posedge clock) disable iff (reset)
      enable && !s1_valid_ff |=> !out_valid_ff)
      else $error("window result without a stage one transfer");
`endif

endmodule

// File: rtl/mf5_lane.sv
// One channel lane: rank each window value by compare matrix and pick
// the middle one. Depends on mf5_pkg.
module mf5_lane
   import mf5_pkg::*;
#(
   parameter int WIN_AREA = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic [WIN_AREA-1:0][PIX_W-1:0] in_vals,
   output logic                           out_valid,
   output logic [PIX_W-1:0]               out_median
);

   localparam int MID    = WIN_AREA / 2;
   localparam int RANK_W = $clog2(WIN_AREA);

   logic                           a_valid_ff, b_valid_ff;
   logic [WIN_AREA-1:0][PIX_W-1:0] a_vals_ff, b_vals_ff;
   logic [WIN_AREA-1:0][WIN_AREA-1:0] a_cmp_in, a_cmp_ff;
   logic [WIN_AREA-1:0]            b_sel_in, b_sel_ff;
   logic [RANK_W-1:0]              rank [WIN_AREA];

   // Compare every pair, ties broken by position
   always_comb begin
      for (int i = 0; i < WIN_AREA; i++) begin
         for (int j = 0; j < WIN_AREA; j++) begin
            a_cmp_in[i][j] = (in_vals[j] < in_vals[i]) ||
                             ((in_vals[j] == in_vals[i]) && (j < i));
         end
      end
   end

   // Rank is the number of values ordered ahead
   always_comb begin
      for (int i = 0; i < WIN_AREA; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WIN_AREA; j++) begin
            rank[i] = rank[i] + RANK_W'(a_cmp_ff[i][j]);
         end
         b_sel_in[i] = (rank[i] == RANK_W'(MID));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_vals_ff <= in_vals;
         a_cmp_ff  <= a_cmp_in;
         b_vals_ff <= a_vals_ff;
         b_sel_ff  <= b_sel_in;
      end
   end

   // Select the value of middle rank
   always_comb begin
      out_median = '0;
      for (int i = 0; i < WIN_AREA; i++) begin
         out_median = out_median | (b_vals_ff[i] & {PIX_W{b_sel_ff[i]}});
      end
   end

   assign out_valid = b_valid_ff;

`ifndef SYNTHESIS
   // Ranks form a permutation, so exactly one value is the median
   a_single_median: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> $onehot(b_sel_ff))
      else $error("median select is not one-hot");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the streaming 5x5 median filter: drives pixels, register
// writes and a stalling receiver, and checks every result against an in-bench predictor.
// Depends on mf5_pkg and median_filter_5x5_stream_unit.
module tb_top;
   import mf5_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_SPARE = 2'd3;   // index past the register list
   localparam int LINES = 4;

   typedef struct packed {
      logic [7:0]  m0;
      logic [7:0]  m1;
      logic [7:0]  m2;
      logic [11:0] row;
      logic [9:0]  col;
      logic        last;
   } median_res_type;

   typedef struct {
      logic       sof;
      logic [7:0] c0, c1, c2;
      bit         typed;
      median_res_type res;
   } pix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, req_tready, req_tuser = 1'b0;
   logic [WORD_W-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 1'b0, rsp_tlast;
   logic [47:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0, csr_prdata;

   // predictor state
   logic [23:0] line_mem [0:LINES*MAX_WIDTH_DEF-1];
   logic [23:0] win [0:4][0:4];
   int unsigned col_pos, row_pos;
   logic [10:0] cfg_width;
   logic [12:0] cfg_height;
   logic [1:0]  cfg_chans;

   median_res_type pending_medians[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;
   logic hold_arm = 1'b0;
   bit hold_done = 0;
   int hold_left = 0;

   median_filter_5x5_stream_unit i_dut (.*);

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("median_filter_5x5_stream_unit regression: fail");
      $finish;
   end

   function automatic logic [7:0] window_rank(int ch);
      logic [7:0] v [0:24];
      logic [7:0] t;
      int n, j;
      n = 0;
      for (int i = 0; i < 5; i++)
         for (int k = 0; k < 5; k++) begin
            v[n] = win[i][k][8*ch +: 8];
            n++;
         end
      for (int i = 1; i < 25; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && v[j-1] > t) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      return v[12];
   endfunction

   // advance the window by one pixel, return 1 when a result is due
   function automatic bit advance_window(logic sof, logic [23:0] px,
                                         output median_res_type r);
      int unsigned ew, eh, ec, c, rw;
      logic [23:0] colv [0:4];
      bit due;
      ew = cfg_width < 5 ? 5 : (cfg_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cfg_width);
      eh = cfg_height < 5 ? 5 : (cfg_height > ROW_LIMIT ? ROW_LIMIT : cfg_height);
      ec = cfg_chans == 0 ? 1 : cfg_chans;
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      rw = row_pos;
      for (int k = 0; k < LINES; k++) colv[k] = line_mem[c*LINES + k];
      colv[LINES] = px;
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
         win[i][4] = colv[i];
      end
      for (int k = 0; k < LINES; k++) line_mem[c*LINES + k] = colv[k+1];
      due = (rw >= 4 && c >= 4);
      r = '0;
      if (due) begin
         r.m0 = window_rank(0);
         r.m1 = ec > 1 ? window_rank(1) : 8'd0;
         r.m2 = ec > 2 ? window_rank(2) : 8'd0;
         r.row = 12'(rw - 2);
         r.col = 10'(c - 2);
         r.last = (rw == eh - 1 && c == ew - 1);
      end
      if (c + 1 >= ew) begin
         col_pos = 0;
         row_pos = (rw + 1 >= eh) ? 0 : rw + 1;
      end else begin
         col_pos = c + 1;
      end
      return due;
   endfunction

   // offer one pixel and wait for its transfer
   task automatic send_pixel(logic sof, logic [7:0] c0, c1, c2, bit typed = 0,
                             median_res_type tres = '0);
      median_res_type r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sof;
      req_tdata <= {c2, c1, c0};
      do @(posedge clock); while (!req_tready);
      if (advance_window(sof, {c2, c1, c0}, r)) pending_medians.push_back(typed ? tres : r);
   endtask

   task automatic csr_access(logic wr, logic [1:0] idx, logic [31:0] val,
                             output logic [31:0] rd);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register, update the predictor and read the value back unless it is the spare index
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      logic [31:0] rd, want;
      csr_access(1'b1, idx, val, rd);
      case (idx)
         REG_WIDTH: begin
            cfg_width = val[10:0];
            want = cfg_width;
         end
         REG_HEIGHT: begin
            cfg_height = val[12:0];
            want = cfg_height;
         end
         REG_CHANNELS: begin
            cfg_chans = val[1:0];
            want = cfg_chans;
         end
         default: want = 'x;
      endcase
      if (idx != REG_SPARE) begin
         csr_access(1'b0, idx, '0, rd);
         if (rd !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, rd);
            errors++;
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // one phase: geometry, then a frame-aligned stream with the odd restart
   task automatic run_phase(logic [31:0] w, h, ch, int n, int si, int ri);
      drain();
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_CHANNELS, ch);
      send_idle = si;
      recv_idle = ri;
      for (int i = 0; i < n; i++)
         send_pixel(i == 0 || $urandom_range(199) == 0, pick_byte(), pick_byte(), pick_byte());
   endtask

   // receiver: random or held-off ready, check each result transfer
   always @(posedge clock) begin
      median_res_type exp_r, got;
      if (rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                 rsp_tdata[35:24], rsp_tdata[45:36], rsp_tlast};
         if (pending_medians.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            exp_r = pending_medians.pop_front();
            if (got.m0 !== exp_r.m0) begin
               $error("median_chan0: expected %0d, got %0d", exp_r.m0, got.m0); errors++;
            end
            if (got.m1 !== exp_r.m1) begin
               $error("median_chan1: expected %0d, got %0d", exp_r.m1, got.m1); errors++;
            end
            if (got.m2 !== exp_r.m2) begin
               $error("median_chan2: expected %0d, got %0d", exp_r.m2, got.m2); errors++;
            end
            if (got.row !== exp_r.row) begin
               $error("center_row: expected %0d, got %0d", exp_r.row, got.row); errors++;
            end
            if (got.col !== exp_r.col) begin
               $error("center_col: expected %0d, got %0d", exp_r.col, got.col); errors++;
            end
            if (got.last !== exp_r.last) begin
               $error("last_of_frame: expected %0d, got %0d", exp_r.last, got.last); errors++;
            end
         end
      end
      if (hold_arm && !hold_done) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      pix_row_type tbl [0:24];
      logic [31:0] rd;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_chans = CHANNELS_RESET;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < LINES*MAX_WIDTH_DEF; i++) line_mem[i] = '0;
      for (int i = 0; i < 5; i++) for (int j = 0; j < 5; j++) win[i][j] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers come out of reset at 640 x 480, three channels
      csr_access(1'b0, REG_WIDTH, '0, rd);
      if (rd !== 32'(WIDTH_RESET)) begin
         $error("image_width: expected %0d, got %0d", WIDTH_RESET, rd); errors++;
      end
      csr_access(1'b0, REG_HEIGHT, '0, rd);
      if (rd !== 32'(HEIGHT_RESET)) begin
         $error("image_height: expected %0d, got %0d", HEIGHT_RESET, rd); errors++;
      end
      csr_access(1'b0, REG_CHANNELS, '0, rd);
      if (rd !== 32'(CHANNELS_RESET)) begin
         $error("channel_count: expected %0d, got %0d", CHANNELS_RESET, rd); errors++;
      end

      // directed 5x5 frame: channel 0 all high, channel 1 all low, channel 2 a ramp;
      // the single result sits at the centre and closes the frame
      csr_write(REG_WIDTH, 5);
      csr_write(REG_HEIGHT, 5);
      csr_write(REG_CHANNELS, 3);
      csr_write(REG_SPARE, 32'hffff_ffff);
      for (int i = 0; i < 25; i++)
         tbl[i] = '{i == 0, 8'd255, 8'd0, 8'(i*10), i == 24,
                    '{8'd255, 8'd0, 8'd120, 12'd2, 10'd2, 1'b1}};
      for (int i = 0; i < 25; i++)
         send_pixel(tbl[i].sof, tbl[i].c0, tbl[i].c1, tbl[i].c2, tbl[i].typed, tbl[i].res);

      // random phases: small frames, clamped geometry, grey and colour
      run_phase(7, 6, 1, 60, 34, 70);
      run_phase(0, 0, 0, 50, 34, 70);
      run_phase(12, 8, 2, 70, 70, 34);
      run_phase(3, 4, 3, 40, 70, 34);
      run_phase(6, 8191, 3, 40, 0, 0);
      // long receiver hold-off once results flow, so the input backs up
      drain();
      csr_write(REG_WIDTH, 16);
      csr_write(REG_HEIGHT, 5);
      csr_write(REG_CHANNELS, 3);
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < 80; i++) begin
         if (i == 68) hold_arm <= 1'b1;
         send_pixel(i == 0, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      run_phase(9, 7, 2, 50, 0, 0);

      drain();
      if (errors == 0) begin
         $display("median_filter_5x5_stream_unit regression: pass");
      end else begin
         $display("median_filter_5x5_stream_unit regression: fail");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/mf5_pkg.sv
rtl/mf5_ram.sv
rtl/mf5_window.sv
rtl/mf5_lane.sv
rtl/median_filter_5x5_stream_unit.sv
tb/sv/tb_top.sv
